[rtl/sml_pkg.sv]
// Shared constants, register indexes and control/status types for the sticky key latch.
package sml_pkg;

  localparam int CODE_W      = 8;
  localparam int MOD_COUNT   = 5;
  localparam int FN_COUNT_DEF = 20;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_LEFT_CTRL  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_LEFT_SHIFT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_LEFT_ALT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_RIGHT_ALT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_LEFT_GUI   = 3'd5;

  // reset values of the modifier code registers, ctrl shift alt altgr gui
  localparam logic [CODE_W-1:0] RST_CODE_LEFT_CTRL  = 8'd224;
  localparam logic [CODE_W-1:0] RST_CODE_LEFT_SHIFT = 8'd225;
  localparam logic [CODE_W-1:0] RST_CODE_LEFT_ALT   = 8'd226;
  localparam logic [CODE_W-1:0] RST_CODE_RIGHT_ALT  = 8'd230;
  localparam logic [CODE_W-1:0] RST_CODE_LEFT_GUI   = 8'd227;

  // event fields
  localparam logic        CMD_PRESS     = 1'b0;
  localparam logic        CMD_RELEASE   = 1'b1;
  localparam logic [7:0]  STICKY_TYPE   = 8'd30;
  localparam logic [7:0]  ORDINARY_TYPE = 8'd0;

  // result fields
  localparam logic ACT_PRESS    = 1'b0;
  localparam logic ACT_RELEASE  = 1'b1;
  localparam logic OUT_ORDINARY = 1'b0;
  localparam logic OUT_FUNCTION = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic toggle;      // apply a sticky press to its latch, emit one beat
    logic scan_start;  // clear the scan position
    logic scan_step;   // examine one latch position, emit if set
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic evt_toggle;      // input beat is a sticky press in range, block enabled
    logic evt_release_all; // input beat releases every latch, block enabled
    logic out_free;        // output register can take a beat this cycle
    logic scan_end;        // scan position is on the last latch
  } status_t;

endpackage

[rtl/sml_ctrl.sv]
// Controller: accepts events and sequences the release-all scan.
module sml_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sml_pkg::status_t status,
  output sml_pkg::cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = !status.out_free;
        accept   = in_valid && status.out_free;
        if (accept && status.evt_toggle) begin
          cmd.toggle = 1'b1;
        end
        if (accept && status.evt_release_all) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.out_free) begin
          cmd.scan_step = 1'b1;
          if (status.scan_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.toggle && (cmd.scan_start || cmd.scan_step)))
    else $error("toggle issued together with scan command");

  a_scan_enters: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> state == ST_SCAN && in_stall)
    else $error("release-all did not enter scan");
`endif

endmodule

[rtl/sml_dp.sv]
// Datapath: config registers, latches, scan counter and output register.
module sml_dp #(
  parameter int FN_COUNT = sml_pkg::FN_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [sml_pkg::CFG_INDEX_W-1:0]      wr_index,
  input  logic [sml_pkg::CFG_DATA_W-1:0]       wr_data,
  input  logic                                 command,
  input  logic [7:0]                           key_code,
  input  logic [7:0]                           key_type,
  input  sml_pkg::cmd_t                        cmd,
  output sml_pkg::status_t                     status,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 action,
  output logic [sml_pkg::CODE_W-1:0]           out_code,
  output logic                                 out_type,
  output logic                                 last
);

  localparam int N  = sml_pkg::MOD_COUNT + FN_COUNT;
  localparam int PW = $clog2(N);

  logic                          enable;
  logic [sml_pkg::CODE_W-1:0]    mod_codes [sml_pkg::MOD_COUNT];
  logic [N-1:0]                  lat;        // [4:0] modifiers, above that function keys
  logic [N-1:0]                  lat_next;
  logic [PW-1:0]                 pos;

  logic [PW-1:0]                 idx;
  logic [N-1:0]                  onehot;
  logic                          hit;
  logic                          is_mod_idx;
  logic [sml_pkg::CODE_W-1:0]    emit_code;
  logic                          rest_zero;
  logic                          load;
  logic                          mod_match;

  // one latch position is looked at per cycle: the scan position or the pressed code
  always_comb begin
    idx        = cmd.scan_step ? pos : key_code[PW-1:0];
    onehot     = N'(1) << idx;
    hit        = lat[idx];
    is_mod_idx = idx < PW'(sml_pkg::MOD_COUNT);
    emit_code  = is_mod_idx ? mod_codes[idx[2:0]]
                            : sml_pkg::CODE_W'(idx) - sml_pkg::CODE_W'(sml_pkg::MOD_COUNT);
    rest_zero  = (lat & ~onehot) == '0;
    load       = cmd.toggle || (cmd.scan_step && hit);
  end

  // a release of an ordinary key carrying a modifier code is not a release-all
  always_comb begin
    mod_match = 1'b0;
    for (int i = 0; i < sml_pkg::MOD_COUNT; i++) begin
      if (key_code == mod_codes[i]) begin
        mod_match = 1'b1;
      end
    end
    mod_match = mod_match && (key_type == sml_pkg::ORDINARY_TYPE);
  end

  always_comb begin
    status.evt_toggle      = enable && command == sml_pkg::CMD_PRESS &&
                             key_type == sml_pkg::STICKY_TYPE && key_code < 8'(N);
    status.evt_release_all = enable && command == sml_pkg::CMD_RELEASE &&
                             key_type != sml_pkg::STICKY_TYPE && !mod_match;
    status.out_free        = !out_valid || !out_stall;
    status.scan_end        = pos == PW'(N - 1);
  end

  always_comb begin
    lat_next = lat;
    if (cmd.toggle) begin
      lat_next = lat ^ onehot;
    end else if (cmd.scan_step) begin
      lat_next = lat & ~onehot;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b1;
      mod_codes[0] <= sml_pkg::RST_CODE_LEFT_CTRL;
      mod_codes[1] <= sml_pkg::RST_CODE_LEFT_SHIFT;
      mod_codes[2] <= sml_pkg::RST_CODE_LEFT_ALT;
      mod_codes[3] <= sml_pkg::RST_CODE_RIGHT_ALT;
      mod_codes[4] <= sml_pkg::RST_CODE_LEFT_GUI;
    end else if (wr_en) begin
      case (wr_index)
        sml_pkg::REG_ENABLE:          enable       <= wr_data[0];
        sml_pkg::REG_CODE_LEFT_CTRL:  mod_codes[0] <= wr_data;
        sml_pkg::REG_CODE_LEFT_SHIFT: mod_codes[1] <= wr_data;
        sml_pkg::REG_CODE_LEFT_ALT:   mod_codes[2] <= wr_data;
        sml_pkg::REG_CODE_RIGHT_ALT:  mod_codes[3] <= wr_data;
        sml_pkg::REG_CODE_LEFT_GUI:   mod_codes[4] <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // latches, scan counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      lat       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      lat <= lat_next;
      if (cmd.scan_start) begin
        pos <= '0;
      end else if (cmd.scan_step) begin
        pos <= pos + PW'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      action   <= cmd.toggle ? hit : sml_pkg::ACT_RELEASE;
      out_code <= emit_code;
      out_type <= is_mod_idx ? sml_pkg::OUT_ORDINARY : sml_pkg::OUT_FUNCTION;
      last     <= cmd.toggle ? 1'b1 : rest_zero;
    end
  end

`ifndef SYNTHESIS
  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step && status.scan_end |=> lat == '0)
    else $error("latches not clear after release-all scan");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> status.out_free)
    else $error("output register overwritten while stalled");

  a_toggle_last: assert property (@(posedge clk) disable iff (rst)
    cmd.toggle |=> out_valid && last)
    else $error("sticky toggle beat not marked last");
`endif

endmodule

[rtl/sticky_modifier_latch.sv]
// Top level of the sticky key latch: controller plus datapath.
//
// Sticky key latch. A press event of key type 30 toggles one latch: codes 0-4
// are ctrl, shift, alt, altgr and gui, codes 5 up to 5+FN_COUNT-1 are function
// layer keys; each toggle emits one beat, a press when the latch sets and a
// release when it clears, with last high. A modifier beat carries the code
// from its configuration register, a function beat carries the function index
// with out_type high. A release event whose type is not 30, and that is not an
// ordinary key carrying one of the five modifier codes, releases every latched
// key in the order ctrl, shift, alt, altgr, gui, function 0 upward, last high
// on the final beat; with nothing latched it emits nothing. While enable is
// low events are taken and dropped. Timing: a toggle beat appears in the
// output register the cycle after the event is taken, and the next event can
// be taken in that same cycle when the output is not stalled. A release-all
// runs a scan counter over the 5+FN_COUNT latch positions, one position per
// cycle whenever the output can take a beat, and waits while it is stalled;
// in_stall stays high for the whole scan. The output register takes one beat
// at a time, so an input or scan step waits while a finished beat is held by
// out_stall. Configuration writes (wr_en, wr_index, wr_data) go straight to
// the registers and belong only to times when no event is in flight.
module sticky_modifier_latch #(
  parameter int FN_COUNT = sml_pkg::FN_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            wr_en,
  input  logic [sml_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [sml_pkg::CFG_DATA_W-1:0]  wr_data,
  // key event channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic [7:0]                      key_code,
  input  logic [7:0]                      key_type,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            action,
  output logic [sml_pkg::CODE_W-1:0]      out_code,
  output logic                            out_type,
  output logic                            last
);

  sml_pkg::cmd_t    cmd;
  sml_pkg::status_t status;

  // state machine: idle / release-all scan
  sml_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // registers, latches, scan position and output beat register
  sml_dp #(
    .FN_COUNT (FN_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .command   (command),
    .key_code  (key_code),
    .key_type  (key_type),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .action    (action),
    .out_code  (out_code),
    .out_type  (out_type),
    .last      (last)
  );

endmodule

[bench/sticky_modifier_latch_tb.sv]
// Testbench for sticky_modifier_latch: directed and random key events checked against a latch predictor.
module sticky_modifier_latch_tb;

  localparam int FN_N          = sml_pkg::FN_COUNT_DEF;
  localparam int LATCH_N       = sml_pkg::MOD_COUNT + FN_N;
  // a release-all scan walks every latch position, one per cycle while the output is free
  localparam int SETTLE_CYCLES = 2 * LATCH_N + 10;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] code;
    logic [7:0] ktype;
  } key_event_t;

  typedef struct packed {
    logic                       act;
    logic [sml_pkg::CODE_W-1:0] code;
    logic                       fn;
    logic                       last;
  } key_beat_t;

  logic clk;
  logic rst = 1'b1;

  logic                            wr_en    = 1'b0;
  logic [sml_pkg::CFG_INDEX_W-1:0] wr_index = sml_pkg::REG_ENABLE;
  logic [sml_pkg::CFG_DATA_W-1:0]  wr_data  = '0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       command  = sml_pkg::CMD_PRESS;
  logic [7:0] key_code = '0;
  logic [7:0] key_type = sml_pkg::ORDINARY_TYPE;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       action;
  logic [sml_pkg::CODE_W-1:0] out_code;
  logic                       out_type;
  logic                       last;

  sticky_modifier_latch dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .key_code(key_code), .key_type(key_type),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .out_code(out_code), .out_type(out_type), .last(last)
  );

  // Shadow copy of the block's registers and latches.
  logic                          en_q;
  logic [sml_pkg::CODE_W-1:0]    mod_code [sml_pkg::MOD_COUNT];
  logic [sml_pkg::MOD_COUNT-1:0] mod_latch;
  logic [FN_N-1:0]               fn_latch;

  key_event_t key_events[$];     // events waiting to be sent
  key_beat_t  key_beats_due[$];  // beats the block owes us, oldest first

  int events_queued   = 0;
  int events_accepted = 0;
  int errors          = 0;
  int cycles          = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_mod_code(input logic [7:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < sml_pkg::MOD_COUNT; i++)
      if (code == mod_code[i]) hit = 1'b1;
    return hit;
  endfunction

  // Predict the beats caused by one accepted event and update the latches.
  task automatic apply_key_event(input key_event_t ev);
    key_beat_t b;
    int idx, n, k;
    idx = ev.code;
    if (!en_q) return;
    if (ev.cmd == sml_pkg::CMD_PRESS) begin
      // only sticky presses inside modifier + function range toggle
      if (ev.ktype == sml_pkg::STICKY_TYPE && idx < LATCH_N) begin
        b.last = 1'b1;
        if (idx < sml_pkg::MOD_COUNT) begin
          b.act  = mod_latch[idx] ? sml_pkg::ACT_RELEASE : sml_pkg::ACT_PRESS;
          b.code = mod_code[idx];
          b.fn   = sml_pkg::OUT_ORDINARY;
          mod_latch[idx] = ~mod_latch[idx];
        end else begin
          b.act  = fn_latch[idx - sml_pkg::MOD_COUNT] ? sml_pkg::ACT_RELEASE
                                                      : sml_pkg::ACT_PRESS;
          b.code = 8'(idx - sml_pkg::MOD_COUNT);
          b.fn   = sml_pkg::OUT_FUNCTION;
          fn_latch[idx - sml_pkg::MOD_COUNT] = ~fn_latch[idx - sml_pkg::MOD_COUNT];
        end
        key_beats_due.push_back(b);
      end
    end else if (ev.ktype != sml_pkg::STICKY_TYPE &&
                 !(ev.ktype == sml_pkg::ORDINARY_TYPE && is_mod_code(ev.code))) begin
      // release-all: modifiers ctrl..gui, then function keys 0 upward
      n = $countones(mod_latch) + $countones(fn_latch);
      k = 0;
      b.act = sml_pkg::ACT_RELEASE;
      for (int i = 0; i < sml_pkg::MOD_COUNT; i++) begin
        if (mod_latch[i]) begin
          k++;
          b.code = mod_code[i];
          b.fn   = sml_pkg::OUT_ORDINARY;
          b.last = (k == n);
          key_beats_due.push_back(b);
        end
      end
      for (int i = 0; i < FN_N; i++) begin
        if (fn_latch[i]) begin
          k++;
          b.code = 8'(i);
          b.fn   = sml_pkg::OUT_FUNCTION;
          b.last = (k == n);
          key_beats_due.push_back(b);
        end
      end
      mod_latch = '0;
      fn_latch  = '0;
    end
  endtask

  task automatic push_event(input logic cmd, input logic [7:0] code, input logic [7:0] ktype);
    key_events.push_back('{cmd, code, ktype});
    events_queued++;
  endtask

  // Register write: one beat on the write port, shadow updated alongside.
  task automatic write_reg(input logic [sml_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sml_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      sml_pkg::REG_ENABLE:          en_q        = data[0];
      sml_pkg::REG_CODE_LEFT_CTRL:  mod_code[0] = data;
      sml_pkg::REG_CODE_LEFT_SHIFT: mod_code[1] = data;
      sml_pkg::REG_CODE_LEFT_ALT:   mod_code[2] = data;
      sml_pkg::REG_CODE_RIGHT_ALT:  mod_code[3] = data;
      sml_pkg::REG_CODE_LEFT_GUI:   mod_code[4] = data;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // Wait until every queued event is taken and every owed beat has come out,
  // then give a scan that emits nothing time to finish.
  task automatic settle();
    while (events_accepted != events_queued || key_beats_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random part: mostly sticky-press runs closed by an ordinary release,
  // plus noise. With with_full set, one run clears and then latches every key first.
  task automatic random_events(input int target, input bit with_full);
    int count, n, off, r;
    logic [7:0] code, ktype;
    count = 0;
    if (with_full) begin
      do code = 8'($urandom_range(0, 255)); while (is_mod_code(code));
      push_event(sml_pkg::CMD_RELEASE, code, sml_pkg::ORDINARY_TYPE);
      off = $urandom_range(0, LATCH_N - 1);
      for (int i = 0; i < LATCH_N; i++)
        push_event(sml_pkg::CMD_PRESS, 8'((i * 7 + off) % LATCH_N), sml_pkg::STICKY_TYPE);
      do code = 8'($urandom_range(0, 255)); while (is_mod_code(code));
      push_event(sml_pkg::CMD_RELEASE, code, sml_pkg::ORDINARY_TYPE);
      count += LATCH_N + 2;
    end
    while (count < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          push_event(sml_pkg::CMD_PRESS, 8'($urandom_range(0, LATCH_N - 1)),
                     sml_pkg::STICKY_TYPE);
          if ($urandom_range(0, 99) < 15)
            push_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        end
        // closing release: usually an ordinary key, sometimes another type
        ktype = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : sml_pkg::ORDINARY_TYPE;
        push_event(sml_pkg::CMD_RELEASE, 8'($urandom_range(0, 255)), ktype);
        count += n + 1;
      end else begin
        case ($urandom_range(0, 2))
          0: ktype = sml_pkg::STICKY_TYPE;
          1: ktype = sml_pkg::ORDINARY_TYPE;
          default: ktype = 8'($urandom_range(0, 255));
        endcase
        push_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), ktype);
        count++;
      end
    end
  endtask

  // Driver: presents queued events; a held beat stays put while stalled.
  always @(posedge clk) begin : drive_events
    key_event_t ev;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_key_event('{command, key_code, key_type});
        events_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (key_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          ev = key_events.pop_front();
          command  <= ev.cmd;
          key_code <= ev.code;
          key_type <= ev.ktype;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each beat taken off the result channel, then picks stall.
  always @(posedge clk) begin : check_beats
    key_beat_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {action, out_code, out_type, last};
        if (key_beats_due.size() == 0) begin
          $display("%0t: unexpected beat act=%0b code=%0d fn=%0b last=%0b",
                   $time, got.act, got.code, got.fn, got.last);
          errors++;
        end else begin
          want = key_beats_due.pop_front();
          if (got.act !== want.act || got.code !== want.code ||
              got.fn !== want.fn || got.last !== want.last) begin
            $display({"%0t: expected act=%0b code=%0d fn=%0b last=%0b,",
                      " got act=%0b code=%0d fn=%0b last=%0b"},
                     $time, want.act, want.code, want.fn, want.last,
                     got.act, got.code, got.fn, got.last);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sticky_modifier_latch_tb NOT OK");
      $finish;
    end
  end

  initial begin
    en_q        = 1'b1;
    mod_code[0] = sml_pkg::RST_CODE_LEFT_CTRL;
    mod_code[1] = sml_pkg::RST_CODE_LEFT_SHIFT;
    mod_code[2] = sml_pkg::RST_CODE_LEFT_ALT;
    mod_code[3] = sml_pkg::RST_CODE_RIGHT_ALT;
    mod_code[4] = sml_pkg::RST_CODE_LEFT_GUI;
    mod_latch   = '0;
    fn_latch    = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sender rarely idle, receiver stalls about half the time
    send_idle_pct = 10;
    recv_idle_pct = 52;

    // Directed part, reset codes.
    for (int i = 0; i < sml_pkg::MOD_COUNT; i++)
      push_event(sml_pkg::CMD_PRESS, 8'(i), sml_pkg::STICKY_TYPE);   // latch every modifier
    push_event(sml_pkg::CMD_PRESS, 8'(sml_pkg::MOD_COUNT), sml_pkg::STICKY_TYPE); // first fn
    push_event(sml_pkg::CMD_PRESS, 8'(LATCH_N - 1), sml_pkg::STICKY_TYPE); // last fn key
    push_event(sml_pkg::CMD_PRESS, 8'(LATCH_N), sml_pkg::STICKY_TYPE); // just past range
    push_event(sml_pkg::CMD_PRESS, 8'd255, sml_pkg::STICKY_TYPE);      // far past range
    push_event(sml_pkg::CMD_PRESS, 8'd4, sml_pkg::ORDINARY_TYPE);      // plain press: nothing
    push_event(sml_pkg::CMD_PRESS, 8'd0, 8'd255);                      // odd type press
    push_event(sml_pkg::CMD_RELEASE, 8'd10, sml_pkg::STICKY_TYPE);     // sticky release
    push_event(sml_pkg::CMD_RELEASE, sml_pkg::RST_CODE_LEFT_CTRL,
               sml_pkg::ORDINARY_TYPE);                                // modifier release
    push_event(sml_pkg::CMD_RELEASE, sml_pkg::RST_CODE_LEFT_GUI, sml_pkg::ORDINARY_TYPE);
    push_event(sml_pkg::CMD_RELEASE, 8'd4, sml_pkg::ORDINARY_TYPE);    // release-all, 7 beats
    push_event(sml_pkg::CMD_RELEASE, 8'd4, sml_pkg::ORDINARY_TYPE);    // nothing latched
    push_event(sml_pkg::CMD_PRESS, 8'd2, sml_pkg::STICKY_TYPE);        // toggle alt on ...
    push_event(sml_pkg::CMD_PRESS, 8'd2, sml_pkg::STICKY_TYPE);        // ... and off again
    push_event(sml_pkg::CMD_PRESS, 8'd12, sml_pkg::STICKY_TYPE);
    push_event(sml_pkg::CMD_RELEASE, sml_pkg::RST_CODE_LEFT_SHIFT, 8'd1); // not ordinary
    settle();

    // Extreme codes, duplicates included.
    write_reg(sml_pkg::REG_ENABLE, 8'd1);
    write_reg(sml_pkg::REG_CODE_LEFT_CTRL, 8'd0);
    write_reg(sml_pkg::REG_CODE_LEFT_SHIFT, 8'd255);
    write_reg(sml_pkg::REG_CODE_LEFT_ALT, 8'd0);
    write_reg(sml_pkg::REG_CODE_RIGHT_ALT, 8'd255);
    write_reg(sml_pkg::REG_CODE_LEFT_GUI, 8'($urandom_range(1, 254)));
    random_events(10, 1'b0);
    settle();   // sender holds off until every owed beat is out
    random_events(30, 1'b1);
    settle();

    // Disabled: events are swallowed.
    send_idle_pct = 52;
    recv_idle_pct = 10;
    write_reg(sml_pkg::REG_ENABLE, 8'd0);
    push_event(sml_pkg::CMD_PRESS, 8'd0, sml_pkg::STICKY_TYPE);
    push_event(sml_pkg::CMD_PRESS, 8'd7, sml_pkg::STICKY_TYPE);
    push_event(sml_pkg::CMD_RELEASE, 8'd4, sml_pkg::ORDINARY_TYPE);
    push_event(sml_pkg::CMD_RELEASE, 8'd9, 8'd5);
    settle();

    // Random codes.
    write_reg(sml_pkg::REG_ENABLE, 8'd1);
    write_reg(sml_pkg::REG_CODE_LEFT_CTRL, 8'($urandom_range(0, 255)));
    write_reg(sml_pkg::REG_CODE_LEFT_SHIFT, 8'($urandom_range(0, 255)));
    write_reg(sml_pkg::REG_CODE_LEFT_ALT, 8'($urandom_range(0, 255)));
    write_reg(sml_pkg::REG_CODE_RIGHT_ALT, 8'($urandom_range(0, 255)));
    write_reg(sml_pkg::REG_CODE_LEFT_GUI, 8'($urandom_range(0, 255)));
    random_events(12, 1'b0);
    settle();

    // Back to reset codes, no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(sml_pkg::REG_CODE_LEFT_CTRL, sml_pkg::RST_CODE_LEFT_CTRL);
    write_reg(sml_pkg::REG_CODE_LEFT_SHIFT, sml_pkg::RST_CODE_LEFT_SHIFT);
    write_reg(sml_pkg::REG_CODE_LEFT_ALT, sml_pkg::RST_CODE_LEFT_ALT);
    write_reg(sml_pkg::REG_CODE_RIGHT_ALT, sml_pkg::RST_CODE_RIGHT_ALT);
    write_reg(sml_pkg::REG_CODE_LEFT_GUI, sml_pkg::RST_CODE_LEFT_GUI);
    random_events(27, 1'b1);
    settle();

    if (errors == 0)
      $display("sticky_modifier_latch_tb OK");
    else
      $display("sticky_modifier_latch_tb NOT OK");
    $finish;
  end

endmodule
